>>> rtl/ste_pkg.sv
// Shared types and constants for the slot table engine.
package ste_pkg;

   localparam int MODE_W      = 3;
   localparam int POS_W       = 8;
   localparam int VAL_W       = 32;
   localparam int ACT_W       = 5;
   localparam int STAT_W      = 3;
   localparam int REQ_TDATA_W = 48;
   localparam int RSP_TDATA_W = 8;
   localparam logic [ACT_W-1:0] ACT_RESET = 5'd16;

   typedef enum logic [MODE_W-1:0] {
      MODE_INSERT  = 3'd0,
      MODE_REMOVE  = 3'd1,
      MODE_PUSH    = 3'd2,
      MODE_UPDATE  = 3'd3,
      MODE_ERASE   = 3'd4,
      MODE_SWAP    = 3'd5,
      MODE_REVERSE = 3'd6
   } mode_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK           = 3'd0,
      STAT_INVALID      = 3'd1,
      STAT_OCCUPIED     = 3'd2,
      STAT_NOT_OCCUPIED = 3'd3,
      STAT_EMPTY        = 3'd4,
      STAT_FULL         = 3'd5
   } stat_type;

   typedef enum logic [3:0] {
      FSM_IDLE,
      FSM_EXEC,
      FSM_SWAP_WR,
      FSM_PUSH_RD,
      FSM_PUSH_CHK,
      FSM_ERASE,
      FSM_REV_RD,
      FSM_REV_WR_LO,
      FSM_REV_WR_HI,
      FSM_DONE
   } state_type;

endpackage

>>> rtl/slot_table_engine_top.sv
// Slot table engine: a table of signed words kept in a memory, edited one request at a time.
//
//   channel  direction  handshake                fields
//   req_     in         req_tvalid/req_tready    tuser: mode; tdata: position, other, value
//   rsp_     out        rsp_tvalid/rsp_tready    tdata: status
//   csr_     in         csr_valid/csr_ready      data: active_slots
//
// Insert, remove, update and erase run without a loop; swap writes its two slots in turn,
// push reads and checks one slot at a time from slot zero, and reverse reads each slot pair
// and writes it back in turn; the single write port of the slot memory sets this order.
// Reset clears one valid bit per slot at once, so no clearing pass follows reset.
// The result register lets a new request be accepted while the last result waits.
module slot_table_engine_top
   import ste_pkg::*;
#(
   parameter int SLOTS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [MODE_W-1:0]      req_tuser,  // [2:0] mode
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // [7:0] position, [15:8] other_position,
                                              // [47:16] value
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,  // [2:0] status, [7:3] zero
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [ACT_W-1:0]       csr_data
);

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W = $clog2(SLOTS + 1);
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
   localparam int LIV_W = (CNT_W > ACT_W) ? CNT_W : ACT_W;

   logic [VAL_W-1:0] slot_mem [SLOTS];
   logic [SLOTS-1:0] vld_ff;

   state_type               state_ff, state_in;
   mode_type                mode_ff;
   logic [POS_W-1:0]        pos_ff, oth_ff;
   logic signed [VAL_W-1:0] val_ff;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [CNT_W-1:0]        hi_ff, hi_in;
   stat_type                stat_ff, stat_in;
   logic                    rsp_valid_ff;
   stat_type                rsp_status_ff;
   logic [ACT_W-1:0]        active_ff;
   logic [VAL_W-1:0]        rda_data_ff, rdb_data_ff;
   logic                    rda_vld_ff, rdb_vld_ff;

   logic             wr_en, rd_en, erase_en, rsp_load, req_accept;
   logic [IDX_W-1:0] wr_addr, rd_a_addr, rd_b_addr;
   logic [VAL_W-1:0] wr_data, a_word, b_word;
   logic [LIV_W-1:0] act_ext, live;
   logic [CNT_W-1:0] n;
   logic             p_bad, q_bad, a_zero, scan_last, rev_more;
   mode_type         req_mode;

   assign req_tready = (state_ff == FSM_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign req_mode   = mode_type'(req_tuser);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'(rsp_status_ff);

   assign act_ext = LIV_W'(active_ff);
   assign live    = (act_ext > LIV_W'(SLOTS)) ? LIV_W'(SLOTS) : act_ext;
   assign n       = CNT_W'(live);

   assign a_word    = rda_vld_ff ? rda_data_ff : '0;
   assign b_word    = rdb_vld_ff ? rdb_data_ff : '0;
   assign a_zero    = (a_word == '0);
   assign p_bad     = CMP_W'(pos_ff) >= CMP_W'(n);
   assign q_bad     = CMP_W'(oth_ff) >= CMP_W'(n);
   assign scan_last = (CNT_W'(cnt_ff + 1'b1) == n);
   assign rev_more  = (CNT_W'(hi_ff - cnt_ff) > CNT_W'(2));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         rsp_valid_ff <= 1'b0;
         active_ff    <= ACT_RESET;
      end else begin
         state_ff <= state_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_valid && csr_ready) begin
            active_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         mode_ff <= req_mode;
         pos_ff  <= req_tdata[POS_W-1:0];
         oth_ff  <= req_tdata[2*POS_W-1:POS_W];
         val_ff  <= req_tdata[2*POS_W+VAL_W-1:2*POS_W];
      end
      cnt_ff  <= cnt_in;
      hi_ff   <= hi_in;
      stat_ff <= stat_in;
      if (rsp_load) begin
         rsp_status_ff <= stat_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rda_data_ff <= slot_mem[rd_a_addr];
         rdb_data_ff <= slot_mem[rd_b_addr];
         rda_vld_ff  <= vld_ff[rd_a_addr];
         rdb_vld_ff  <= vld_ff[rd_b_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (erase_en) begin
         for (int i = 0; i < SLOTS; i++) begin
            if (CNT_W'(i) < n) begin
               vld_ff[i] <= 1'b0;
            end
         end
      end else if (wr_en) begin
         vld_ff[wr_addr] <= 1'b1;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FSM_IDLE: begin
            if (req_accept) begin
               if (req_mode inside {MODE_INSERT, MODE_REMOVE, MODE_UPDATE, MODE_SWAP}) begin
                  state_in = FSM_EXEC;
               end else if (req_mode == MODE_PUSH) begin
                  state_in = (n == '0) ? FSM_DONE : FSM_PUSH_RD;
               end else if (req_mode == MODE_ERASE) begin
                  state_in = FSM_ERASE;
               end else if (req_mode == MODE_REVERSE) begin
                  state_in = (n < CNT_W'(2)) ? FSM_DONE : FSM_REV_RD;
               end else begin
                  state_in = FSM_DONE;
               end
            end
         end
         FSM_EXEC: begin
            state_in = (mode_ff == MODE_SWAP && !p_bad && !q_bad) ? FSM_SWAP_WR : FSM_DONE;
         end
         FSM_SWAP_WR:   state_in = FSM_DONE;
         FSM_PUSH_RD:   state_in = FSM_PUSH_CHK;
         FSM_PUSH_CHK:  state_in = (a_zero || scan_last) ? FSM_DONE : FSM_PUSH_RD;
         FSM_ERASE:     state_in = FSM_DONE;
         FSM_REV_RD:    state_in = FSM_REV_WR_LO;
         FSM_REV_WR_LO: state_in = FSM_REV_WR_HI;
         FSM_REV_WR_HI: state_in = rev_more ? FSM_REV_RD : FSM_DONE;
         FSM_DONE: begin
            if (rsp_load) begin
               state_in = FSM_IDLE;
            end
         end
         default: state_in = FSM_IDLE;
      endcase
   end

   always_comb begin
      wr_en     = 1'b0;
      wr_addr   = pos_ff[IDX_W-1:0];
      wr_data   = val_ff;
      rd_en     = 1'b0;
      rd_a_addr = pos_ff[IDX_W-1:0];
      rd_b_addr = oth_ff[IDX_W-1:0];
      erase_en  = 1'b0;
      rsp_load  = 1'b0;
      cnt_in    = cnt_ff;
      hi_in     = hi_ff;
      stat_in   = stat_ff;
      case (state_ff)
         FSM_IDLE: begin
            rd_a_addr = req_tdata[IDX_W-1:0];
            rd_b_addr = req_tdata[POS_W+IDX_W-1:POS_W];
            rd_en     = req_accept;
            if (req_accept) begin
               cnt_in  = '0;
               hi_in   = CNT_W'(n - 1'b1);
               stat_in = STAT_OK;
               if (req_mode == MODE_PUSH && n == '0) begin
                  stat_in = STAT_FULL;
               end else if (!(req_mode inside {MODE_INSERT, MODE_REMOVE, MODE_PUSH,
                                               MODE_UPDATE, MODE_ERASE, MODE_SWAP,
                                               MODE_REVERSE})) begin
                  stat_in = STAT_INVALID;
               end
            end
         end
         FSM_EXEC: begin
            case (mode_ff)
               MODE_INSERT: begin
                  if (p_bad) begin
                     stat_in = STAT_INVALID;
                  end else if (!a_zero) begin
                     stat_in = STAT_OCCUPIED;
                  end else begin
                     wr_en   = 1'b1;
                     stat_in = STAT_OK;
                  end
               end
               MODE_REMOVE: begin
                  wr_data = '0;
                  if (p_bad) begin
                     stat_in = STAT_INVALID;
                  end else if (a_zero) begin
                     stat_in = STAT_EMPTY;
                  end else begin
                     wr_en   = 1'b1;
                     stat_in = STAT_OK;
                  end
               end
               MODE_UPDATE: begin
                  if (p_bad) begin
                     stat_in = STAT_INVALID;
                  end else if (a_zero) begin
                     stat_in = STAT_NOT_OCCUPIED;
                  end else begin
                     wr_en   = 1'b1;
                     stat_in = STAT_OK;
                  end
               end
               MODE_SWAP: begin
                  wr_data = b_word;
                  if (p_bad || q_bad) begin
                     stat_in = STAT_INVALID;
                  end else begin
                     wr_en   = 1'b1;
                     stat_in = STAT_OK;
                  end
               end
               default: stat_in = STAT_INVALID;
            endcase
         end
         FSM_SWAP_WR: begin
            wr_en   = 1'b1;
            wr_addr = oth_ff[IDX_W-1:0];
            wr_data = a_word;
         end
         FSM_PUSH_RD: begin
            rd_en     = 1'b1;
            rd_a_addr = cnt_ff[IDX_W-1:0];
         end
         FSM_PUSH_CHK: begin
            wr_addr = cnt_ff[IDX_W-1:0];
            if (a_zero) begin
               wr_en   = 1'b1;
               stat_in = STAT_OK;
            end else if (scan_last) begin
               stat_in = STAT_FULL;
            end else begin
               cnt_in = CNT_W'(cnt_ff + 1'b1);
            end
         end
         FSM_ERASE: begin
            erase_en = 1'b1;
         end
         FSM_REV_RD: begin
            rd_en     = 1'b1;
            rd_a_addr = cnt_ff[IDX_W-1:0];
            rd_b_addr = hi_ff[IDX_W-1:0];
         end
         FSM_REV_WR_LO: begin
            wr_en   = 1'b1;
            wr_addr = cnt_ff[IDX_W-1:0];
            wr_data = b_word;
         end
         FSM_REV_WR_HI: begin
            wr_en   = 1'b1;
            wr_addr = hi_ff[IDX_W-1:0];
            wr_data = a_word;
            cnt_in  = CNT_W'(cnt_ff + 1'b1);
            hi_in   = CNT_W'(hi_ff - 1'b1);
         end
         FSM_DONE: begin
            rsp_load = !rsp_valid_ff || rsp_tready;
         end
         default: ;
      endcase
   end

   a_no_write_during_erase: assert property (@(posedge clock) disable iff (reset)
      !(wr_en && erase_en))
      else $error("Slot write and erase occur in the same cycle.");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> state_ff != FSM_IDLE)
      else $error("Engine is idle right after accepting a request.");

   a_done_waits_for_slot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == FSM_DONE && rsp_valid_ff && !rsp_tready) |=> state_ff == FSM_DONE)
      else $error("Result dropped while the result register was full.");

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (wr_addr < SLOTS))
      else $error("Slot write address is beyond the table.");

   a_reverse_ordered: assert property (@(posedge clock) disable iff (reset)
      (state_ff == FSM_REV_RD) |-> (cnt_ff < hi_ff))
      else $error("Reverse pass read a pair that is out of order.");

endmodule
